// File: rtl/dbs_pkg.sv
// shared types and constants of the depth background subtractor
package dbs_pkg;

  localparam int MAX_PIXELS = 524288;
  localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int POS_W      = $clog2(MAX_PIXELS + 1);

  localparam int PIX_W      = 8;
  localparam int THRESH_W   = 9;
  localparam int REFRESH_W  = 16;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [PIX_W-1:0]     MASK_FG       = 8'hFF;
  localparam logic [PIX_W-1:0]     MASK_BG       = 8'h00;
  localparam logic [THRESH_W-1:0]  THRESH_RESET  = 9'd3;
  localparam logic [REFRESH_W-1:0] REFRESH_RESET = 16'd300;
  localparam logic [REFRESH_W-1:0] COUNT_MAX     = 16'hFFFF;

  // register index, taken from paddr[2]
  localparam logic REG_DIFF_THRESHOLD = 1'b0;
  localparam logic REG_REFRESH_FRAMES = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] mask;
    logic             mask_frame_end;
    logic             overflow;
  } mask_out_t;

  typedef struct packed {
    logic [THRESH_W-1:0]  diff_threshold;
    logic [REFRESH_W-1:0] refresh_frames;
  } cfg_t;

  // per-item tag from the frame sequencer to the mask stage
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             overflow;
    logic             capture;
    logic             refresh;
  } tag_t;

endpackage

// File: rtl/dbs_ram.sv
// generic single-port ram with registered read
module dbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic                           re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  logic [WIDTH-1:0]               wdata,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/dbs_regs.sv
// configuration registers behind the apb port
module dbs_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dbs_pkg::PADDR_W-1:0] paddr,
  input  logic [dbs_pkg::PDATA_W-1:0] pwdata,
  output logic [dbs_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output dbs_pkg::cfg_t               cfg
);

  logic wr;
  logic idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diff_threshold <= dbs_pkg::THRESH_RESET;
      cfg.refresh_frames <= dbs_pkg::REFRESH_RESET;
    end else if (wr) begin
      case (idx)
        dbs_pkg::REG_DIFF_THRESHOLD: begin
          cfg.diff_threshold <= pwdata[dbs_pkg::THRESH_W-1:0];
        end
        dbs_pkg::REG_REFRESH_FRAMES: begin
          cfg.refresh_frames <= pwdata[dbs_pkg::REFRESH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      dbs_pkg::REG_DIFF_THRESHOLD: begin
        prdata = {{(dbs_pkg::PDATA_W-dbs_pkg::THRESH_W){1'b0}}, cfg.diff_threshold};
      end
      dbs_pkg::REG_REFRESH_FRAMES: begin
        prdata = {{(dbs_pkg::PDATA_W-dbs_pkg::REFRESH_W){1'b0}}, cfg.refresh_frames};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

// File: rtl/dbs_frame_ctrl.sv
// frame sequencer: pixel position, capture and refresh decisions, store access
module dbs_frame_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  dbs_pkg::pix_in_t           pix,
  input  logic [dbs_pkg::REFRESH_W-1:0] refresh_frames,
  output logic                       mem_we,
  output logic                       mem_re,
  output logic [dbs_pkg::ADDR_W-1:0] mem_addr,
  output logic [dbs_pkg::PIX_W-1:0]  mem_wdata,
  output dbs_pkg::tag_t              tag
);

  logic                          bg_valid;
  logic                          pending;
  logic [dbs_pkg::REFRESH_W-1:0] frames;
  logic [dbs_pkg::POS_W-1:0]     pos;
  logic                          refreshing;

  logic                          capture;
  logic                          start;
  logic                          ovf;
  logic [dbs_pkg::REFRESH_W-1:0] frames_inc;
  logic                          refresh_hit;
  logic                          refresh_now;

  assign capture     = !bg_valid;
  assign start       = !capture && (pos == '0);
  assign ovf         = pos >= dbs_pkg::POS_W'(dbs_pkg::MAX_PIXELS);
  assign frames_inc  = (frames == dbs_pkg::COUNT_MAX) ? frames
                                                      : frames + dbs_pkg::REFRESH_W'(1);
  assign refresh_hit = start && !pending && (frames_inc > refresh_frames);
  assign refresh_now = refreshing || refresh_hit;

  assign mem_addr  = pos[dbs_pkg::ADDR_W-1:0];
  assign mem_wdata = pix.pixel;
  assign mem_we    = accept && !ovf && (capture || refresh_now);
  assign mem_re    = accept;

  assign tag.pixel    = pix.pixel;
  assign tag.last     = pix.frame_end;
  assign tag.overflow = ovf;
  assign tag.capture  = capture;
  assign tag.refresh  = refresh_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_valid   <= 1'b0;
      pending    <= 1'b1;
      frames     <= '0;
      pos        <= '0;
      refreshing <= 1'b0;
    end else if (accept) begin
      if (start) begin
        if (pending) begin
          pending <= 1'b0;
          frames  <= '0;
        end else if (refresh_hit) begin
          frames <= '0;
        end else begin
          frames <= frames_inc;
        end
      end
      if (pix.frame_end) begin
        pos        <= '0;
        refreshing <= 1'b0;
        if (capture) begin
          bg_valid <= 1'b1;
        end
      end else begin
        if (refresh_hit) begin
          refreshing <= 1'b1;
        end
        if (!ovf) begin
          pos <= pos + dbs_pkg::POS_W'(1);
        end
      end
    end
  end

endmodule

// File: rtl/dbs_mask_stage.sv
// compare stage and output register
module dbs_mask_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  dbs_pkg::tag_t                tag_in,
  input  logic [dbs_pkg::PIX_W-1:0]    bg,
  input  logic [dbs_pkg::THRESH_W-1:0] diff_threshold,
  output logic                         stall,
  output logic                         res_valid,
  input  logic                         res_stall,
  output dbs_pkg::mask_out_t           res
);

  logic                       s1_valid;
  dbs_pkg::tag_t              s1;
  logic                       adv;
  logic [dbs_pkg::PIX_W-1:0]  diff;
  logic                       hit;
  dbs_pkg::mask_out_t         res_next;

  assign adv   = !res_valid || !res_stall;
  assign stall = s1_valid && !adv;

  assign diff = (s1.pixel >= bg) ? (s1.pixel - bg) : (bg - s1.pixel);

  always_comb begin
    if (s1.overflow || s1.capture) begin
      hit = 1'b0;
    end else if (s1.refresh) begin
      // pixel compared with itself
      hit = (diff_threshold == '0);
    end else begin
      hit = {1'b0, diff} >= diff_threshold;
    end
    res_next.mask           = hit ? dbs_pkg::MASK_FG : dbs_pkg::MASK_BG;
    res_next.mask_frame_end = s1.last;
    res_next.overflow       = s1.overflow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (adv) begin
        res_valid <= s1_valid;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= tag_in;
    end
    if (adv && s1_valid) begin
      res <= res_next;
    end
  end

endmodule

// File: rtl/depth_background_subtractor_unit.sv
// top level of the depth background subtractor
// an accepted pixel is registered in the compare stage, then in the output register
// throughput: one pixel per cycle while not stalled, set by the single background
//   ram port (one address per pixel, read and write share it) and the compare stage
// reset: control state resets, diff_threshold 3, refresh_frames 300;
//   the background ram is not cleared, the first frame fills it
module depth_background_subtractor_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pix_valid,
  output logic                        pix_stall,
  input  dbs_pkg::pix_in_t            pix,
  output logic                        res_valid,
  input  logic                        res_stall,
  output dbs_pkg::mask_out_t          res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dbs_pkg::PADDR_W-1:0] paddr,
  input  logic [dbs_pkg::PDATA_W-1:0] pwdata,
  output logic [dbs_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  dbs_pkg::cfg_t              cfg;
  dbs_pkg::tag_t              tag;
  logic                       accept;
  logic                       mem_we;
  logic                       mem_re;
  logic [dbs_pkg::ADDR_W-1:0] mem_addr;
  logic [dbs_pkg::PIX_W-1:0]  mem_wdata;
  logic [dbs_pkg::PIX_W-1:0]  mem_rdata;

  assign accept = pix_valid && !pix_stall;

  dbs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dbs_frame_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .pix            (pix),
    .refresh_frames (cfg.refresh_frames),
    .mem_we         (mem_we),
    .mem_re         (mem_re),
    .mem_addr       (mem_addr),
    .mem_wdata      (mem_wdata),
    .tag            (tag)
  );

  // read data only changes on an accepted item, so it holds while stalled
  dbs_ram #(
    .WIDTH (dbs_pkg::PIX_W),
    .DEPTH (dbs_pkg::MAX_PIXELS)
  ) u_bg_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  dbs_mask_stage u_mask (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .tag_in         (tag),
    .bg             (mem_rdata),
    .diff_threshold (cfg.diff_threshold),
    .stall          (pix_stall),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .res            (res)
  );

`ifndef SYNTHESIS
  a_no_stall_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !pix_stall)
    else $error("input stalled while output register empty");

  a_overflow_mask_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.overflow) |-> (res.mask == dbs_pkg::MASK_BG))
    else $error("overflow item with nonzero mask");

  a_mask_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.mask == dbs_pkg::MASK_BG || res.mask == dbs_pkg::MASK_FG))
    else $error("mask is neither background nor foreground");

  a_write_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> accept)
    else $error("background write without accepted item");
`endif

endmodule

// File: verif/tb.sv
// self-checking testbench of the depth background subtractor
module tb;

  localparam int STALL_LIMIT = 500;
  // background frame length; no compare frame is longer
  localparam int BG_LEN = 64;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         pix_valid = 1'b0;
  logic                         pix_stall;
  dbs_pkg::pix_in_t             pix = '0;
  logic                         res_valid;
  logic                         res_stall = 1'b0;
  dbs_pkg::mask_out_t           res;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [dbs_pkg::PADDR_W-1:0]  paddr = '0;
  logic [dbs_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [dbs_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  depth_background_subtractor_unit DUT (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // shadow of the block state
  bit [dbs_pkg::PIX_W-1:0]     bg_store [dbs_pkg::MAX_PIXELS];
  bit                          bg_ready = 1'b0;
  bit                          arm_pending = 1'b1;
  bit [dbs_pkg::REFRESH_W-1:0] frame_count = '0;
  bit [dbs_pkg::POS_W-1:0]     pos = '0;
  bit                          refresh_now = 1'b0;
  bit [dbs_pkg::THRESH_W-1:0]  thr = dbs_pkg::THRESH_RESET;
  bit [dbs_pkg::REFRESH_W-1:0] refresh_lim = dbs_pkg::REFRESH_RESET;

  dbs_pkg::pix_in_t   pending [$];
  dbs_pkg::mask_out_t expected_masks [$];

  int unsigned in_pushed = 0;
  int unsigned in_accepted = 0;
  int unsigned frames_done = 0;
  int unsigned fg_seen = 0;
  int unsigned ovf_seen = 0;
  int unsigned refresh_seen = 0;
  int unsigned bad = 0;
  int unsigned send_wait = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  bit          item_taken = 1'b0;
  bit          res_taken = 1'b0;
  bit          no_idle = 1'b0;

  function automatic dbs_pkg::mask_out_t predict_mask(input dbs_pkg::pix_in_t p);
    dbs_pkg::mask_out_t        r;
    logic                      cap;
    logic [dbs_pkg::PIX_W-1:0] d;
    r = '0;
    r.mask_frame_end = p.frame_end;
    cap = !bg_ready;
    if (!cap && pos == 0) begin
      if (arm_pending) begin
        arm_pending = 1'b0;
        frame_count = '0;
      end else begin
        if (frame_count != dbs_pkg::COUNT_MAX) frame_count++;
        if (frame_count > refresh_lim) begin
          refresh_now = 1'b1;
          frame_count = '0;
          refresh_seen++;
        end
      end
    end
    if (pos >= dbs_pkg::MAX_PIXELS) begin
      r.overflow = 1'b1;
      ovf_seen++;
    end else if (cap) begin
      bg_store[pos] = p.pixel;
    end else begin
      if (refresh_now) bg_store[pos] = p.pixel;
      d = (p.pixel >= bg_store[pos]) ? p.pixel - bg_store[pos] : bg_store[pos] - p.pixel;
      r.mask = ({1'b0, d} >= thr) ? dbs_pkg::MASK_FG : dbs_pkg::MASK_BG;
      if (r.mask == dbs_pkg::MASK_FG) fg_seen++;
    end
    if (p.frame_end) begin
      pos = '0;
      refresh_now = 1'b0;
      if (cap) bg_ready = 1'b1;
      frames_done++;
    end else if (pos < dbs_pkg::MAX_PIXELS) begin
      pos++;
    end
    return r;
  endfunction

  // item acceptance on both channels, prediction and check
  always @(posedge clk) begin : mon
    dbs_pkg::mask_out_t want;
    if (!rst) begin
      if (pix_valid && !pix_stall) begin
        expected_masks.push_back(predict_mask(pix));
        in_accepted++;
        item_taken = 1'b1;
      end
      if (res_valid && !res_stall) begin
        res_taken = 1'b1;
        if (expected_masks.size() == 0) begin
          bad++;
          if (bad <= 10) $display("unexpected mask item: mask %0d frame_end %b overflow %b",
                                  res.mask, res.mask_frame_end, res.overflow);
        end else begin
          want = expected_masks.pop_front();
          if (res.mask !== want.mask || res.mask_frame_end !== want.mask_frame_end ||
              res.overflow !== want.overflow) begin
            bad++;
            if (bad <= 10)
              $display("mask mismatch: mask %0d/%0d frame_end %b/%b overflow %b/%b (exp/got)",
                       want.mask, res.mask, want.mask_frame_end, res.mask_frame_end,
                       want.overflow, res.overflow);
          end
        end
      end
    end
  end

  // pixel sender
  always @(negedge clk) begin : drv
    logic             nv;
    dbs_pkg::pix_in_t np;
    nv = pix_valid;
    np = pix;
    if (pix_valid && item_taken) begin
      item_taken = 1'b0;
      nv = 1'b0;
      send_wait = no_idle ? 0 : $urandom_range(0, 7);
    end
    if (!nv) begin
      if (send_wait != 0) begin
        send_wait--;
      end else if (pending.size() != 0) begin
        np = pending.pop_front();
        nv = 1'b1;
      end
    end
    pix_valid <= nv;
    pix <= np;
  end

  // mask receiver, stalls a random count of valid cycles per item
  always @(negedge clk) begin : rcv
    if (res_taken) begin
      res_taken = 1'b0;
      stall_left = no_idle ? 0 : $urandom_range(0, 7);
    end
    res_stall <= (stall_left != 0);
    if (stall_left != 0 && res_valid) stall_left--;
  end

  always @(posedge clk) begin : wdog
    if ((pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic push_pix(input logic [dbs_pkg::PIX_W-1:0] value, input logic last);
    dbs_pkg::pix_in_t p;
    p.pixel = value;
    p.frame_end = last;
    pending.push_back(p);
    in_pushed++;
  endtask

  task automatic settle();
    while (in_accepted != in_pushed || expected_masks.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [dbs_pkg::PDATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == dbs_pkg::REG_DIFF_THRESHOLD) thr = value[dbs_pkg::THRESH_W-1:0];
    else refresh_lim = value[dbs_pkg::REFRESH_W-1:0];
  endtask

  // random pixel, often close to the stored background
  function automatic logic [dbs_pkg::PIX_W-1:0] pick_pixel(input int idx);
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 255;
      2, 3, 4: v = $urandom_range(0, 255);
      default: begin
        v = int'(bg_store[idx]) + int'($urandom_range(0, 8)) - 4;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
    endcase
    return v[dbs_pkg::PIX_W-1:0];
  endfunction

  // split >= 0 holds the sender mid-frame until every mask is back
  task automatic push_frame(input int len, input int split);
    for (int i = 0; i < len; i++) begin
      push_pix(pick_pixel(i), i == len - 1);
      if (i == split) settle();
    end
  endtask

  function automatic logic [dbs_pkg::PDATA_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 256;
      2: return $urandom_range(0, 256);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic logic [dbs_pkg::PDATA_W-1:0] pick_refresh();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(0, 65535);
      default: return $urandom_range(0, 4);
    endcase
  endfunction

  initial begin
    int len;
    int phase_items;
    int rand_items;
    bit first;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // background frame, back to back, covers every position later compared
    no_idle = 1'b1;
    push_pix(8'd0, 1'b0);
    push_pix(8'd255, 1'b0);
    push_pix(8'd0, 1'b0);
    push_pix(8'd255, 1'b0);
    for (int i = 4; i < 8; i++) push_pix(8'd100, 1'b0);
    for (int i = 8; i < BG_LEN; i++)
      push_pix(dbs_pkg::PIX_W'($urandom_range(0, 255)), i == BG_LEN - 1);
    settle();
    no_idle = 1'b0;

    // arming frame at reset threshold: full swings, and differences around 3
    push_pix(8'd255, 1'b0);
    push_pix(8'd0, 1'b0);
    push_pix(8'd0, 1'b0);
    push_pix(8'd255, 1'b0);
    push_pix(8'd97, 1'b0);
    push_pix(8'd98, 1'b0);
    push_pix(8'd103, 1'b0);
    push_pix(8'd102, 1'b1);
    settle();

    // zero threshold with immediate refresh: every pixel compares to itself
    write_reg(dbs_pkg::REG_DIFF_THRESHOLD, 0);
    write_reg(dbs_pkg::REG_REFRESH_FRAMES, 0);
    push_pix(8'd7, 1'b0);
    push_pix(8'd200, 1'b0);
    push_pix(8'd0, 1'b0);
    push_pix(8'd255, 1'b1);
    push_pix(8'd7, 1'b0);
    push_pix(8'd200, 1'b1);
    settle();

    // threshold above any difference
    write_reg(dbs_pkg::REG_DIFF_THRESHOLD, 256);
    write_reg(dbs_pkg::REG_REFRESH_FRAMES, 65535);
    push_pix(8'd100, 1'b0);
    push_pix(8'd0, 1'b0);
    push_pix(8'd255, 1'b0);
    push_pix(8'd0, 1'b1);
    settle();

    // long refresh interval at the smallest nonzero threshold
    write_reg(dbs_pkg::REG_DIFF_THRESHOLD, 1);
    write_reg(dbs_pkg::REG_REFRESH_FRAMES, 1000);
    push_frame(3, -1);
    push_frame(3, -1);

    rand_items = 0;
    first = 1'b1;
    while (rand_items < 600) begin
      settle();
      write_reg(dbs_pkg::REG_DIFF_THRESHOLD, pick_threshold());
      write_reg(dbs_pkg::REG_REFRESH_FRAMES, pick_refresh());
      phase_items = 0;
      while (phase_items < 100) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, BG_LEN) : $urandom_range(1, 24);
        no_idle = ($urandom_range(0, 5) == 0);
        push_frame(len, first ? len / 2 : -1);
        first = 1'b0;
        phase_items += len;
      end
      rand_items += phase_items;
    end

    settle();
    no_idle = 1'b0;
    repeat (10) @(negedge clk);
    $display("%0d pixels in %0d frames: %0d foreground, %0d past capacity, %0d refresh frames",
             in_accepted, frames_done, fg_seen, ovf_seen, refresh_seen);
    $display("%0d mask errors", bad);
    if (bad == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
